// File: rtl/tfn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle face normal package
// Shared widths, codes and payload types of the face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int DEPTH    = 1024;
  localparam int VIDX_W   = $clog2(DEPTH);
  localparam int COORD_W  = 16;
  localparam int EDGE_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * EDGE_W;
  localparam int CROSS_W  = PROD_W + 1;
  localparam int MAG_W    = PROD_W;
  localparam int HALF_W   = MAG_W / 2;
  localparam int HPROD_W  = 2 * HALF_W;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int SUM_W    = SQ_W + 2;
  localparam int Q_W      = 15;
  localparam int Q_STAGES = Q_W;
  localparam int T_SHIFT  = 2 * Q_W;
  localparam int A_SHIFT  = Q_W + 1;
  localparam int B_SHIFT  = 2 * Q_W;
  localparam int RES_W    = SUM_W + B_SHIFT + 4;
  localparam int FACE_W   = 12;
  localparam int NORM_W   = 16;
  localparam int LANES    = 3;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_FACE = 1'b1
  } op_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic              valid;
    logic [FACE_W-1:0] face;
    logic [LANES-1:0]  neg;
    logic              zero;
  } ctrl_t;

  typedef logic signed [RES_W-1:0] res_t;

endpackage

// File: rtl/tfn_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying vertex loads and face requests.
// ----------------------------------------------------------------------------
interface tfn_in_if;
  logic                               valid;
  logic                               ready;
  logic                               operation;
  logic [tfn_pkg::VIDX_W-1:0]         vertex_index;
  logic signed [tfn_pkg::COORD_W-1:0] coord_x;
  logic signed [tfn_pkg::COORD_W-1:0] coord_y;
  logic signed [tfn_pkg::COORD_W-1:0] coord_z;
  logic [tfn_pkg::VIDX_W-1:0]         corner_a;
  logic [tfn_pkg::VIDX_W-1:0]         corner_b;
  logic [tfn_pkg::VIDX_W-1:0]         corner_c;
  logic [tfn_pkg::FACE_W-1:0]         face_index;

  modport source (output valid, operation, vertex_index, coord_x, coord_y, coord_z,
                  corner_a, corner_b, corner_c, face_index, input ready);
  modport sink (input valid, operation, vertex_index, coord_x, coord_y, coord_z,
                corner_a, corner_b, corner_c, face_index, output ready);
endinterface

// File: rtl/tfn_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one unit normal per face.
// ----------------------------------------------------------------------------
interface tfn_out_if;
  logic                              valid;
  logic                              ready;
  logic [tfn_pkg::FACE_W-1:0]        face_number;
  logic signed [tfn_pkg::NORM_W-1:0] normal_x;
  logic signed [tfn_pkg::NORM_W-1:0] normal_y;
  logic signed [tfn_pkg::NORM_W-1:0] normal_z;
  logic                              degenerate;

  modport source (output valid, face_number, normal_x, normal_y, normal_z, degenerate,
                  input ready);
  modport sink (input valid, face_number, normal_x, normal_y, normal_z, degenerate,
                output ready);
endinterface

// File: rtl/tfn_vertex_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex store
// Three copies of the vertex memory, one read port each, written together.
// ----------------------------------------------------------------------------
module tfn_vertex_store (
  input  logic                                       clk,
  input  logic                                       en,
  input  logic                                       wr_en,
  input  logic [tfn_pkg::VIDX_W-1:0]                 wr_idx,
  input  tfn_pkg::vertex_t                           wr_data,
  input  logic [tfn_pkg::LANES-1:0][tfn_pkg::VIDX_W-1:0] rd_idx,
  output tfn_pkg::vertex_t                           rd_data [tfn_pkg::LANES]
);

  for (genvar g = 0; g < tfn_pkg::LANES; g++) begin : g_copy
    tfn_pkg::vertex_t mem [tfn_pkg::DEPTH];
    tfn_pkg::vertex_t rd_q;

    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[wr_idx] <= wr_data;
      end
      // hold the read word while the pipeline is stalled
      if (en) begin
        rd_q <= mem[rd_idx[g]];
      end
    end

    assign rd_data[g] = rd_q;
  end

endmodule

// File: rtl/tfn_cross.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cross product stages
// Edges, six partial products, then signed cross product split into
// magnitude, sign and a zero flag. Three register stages.
// ----------------------------------------------------------------------------
module tfn_cross (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  tfn_pkg::ctrl_t          in_ctrl,
  input  tfn_pkg::vertex_t        va,
  input  tfn_pkg::vertex_t        vb,
  input  tfn_pkg::vertex_t        vc,
  output tfn_pkg::ctrl_t          out_ctrl,
  output logic [tfn_pkg::MAG_W-1:0] mag [tfn_pkg::LANES]
);

  logic signed [tfn_pkg::COORD_W-1:0] ca [tfn_pkg::LANES];
  logic signed [tfn_pkg::COORD_W-1:0] cb [tfn_pkg::LANES];
  logic signed [tfn_pkg::COORD_W-1:0] cc [tfn_pkg::LANES];
  logic signed [tfn_pkg::EDGE_W-1:0]  e1 [tfn_pkg::LANES];
  logic signed [tfn_pkg::EDGE_W-1:0]  e2 [tfn_pkg::LANES];
  logic signed [tfn_pkg::PROD_W-1:0]  prod [6];
  logic signed [tfn_pkg::CROSS_W-1:0] n [tfn_pkg::LANES];
  logic [tfn_pkg::CROSS_W-1:0]        nabs [tfn_pkg::LANES];
  tfn_pkg::ctrl_t                     c_e;
  tfn_pkg::ctrl_t                     c_p;

  assign ca[0] = va.x;
  assign ca[1] = va.y;
  assign ca[2] = va.z;
  assign cb[0] = vb.x;
  assign cb[1] = vb.y;
  assign cb[2] = vb.z;
  assign cc[0] = vc.x;
  assign cc[1] = vc.y;
  assign cc[2] = vc.z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < tfn_pkg::LANES; i++) begin
        e1[i] <= {cb[i][tfn_pkg::COORD_W-1], cb[i]} - {ca[i][tfn_pkg::COORD_W-1], ca[i]};
        e2[i] <= {cc[i][tfn_pkg::COORD_W-1], cc[i]} - {cb[i][tfn_pkg::COORD_W-1], cb[i]};
      end
      prod[0] <= e1[1] * e2[2];
      prod[1] <= e1[2] * e2[1];
      prod[2] <= e1[2] * e2[0];
      prod[3] <= e1[0] * e2[2];
      prod[4] <= e1[0] * e2[1];
      prod[5] <= e1[1] * e2[0];
    end
  end

  always_comb begin
    for (int i = 0; i < tfn_pkg::LANES; i++) begin
      n[i] = {prod[2*i][tfn_pkg::PROD_W-1], prod[2*i]}
           - {prod[2*i+1][tfn_pkg::PROD_W-1], prod[2*i+1]};
      nabs[i] = n[i][tfn_pkg::CROSS_W-1] ? tfn_pkg::CROSS_W'(-n[i]) : n[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < tfn_pkg::LANES; i++) begin
        mag[i] <= nabs[i][tfn_pkg::MAG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_e.valid      <= 1'b0;
      c_p.valid      <= 1'b0;
      out_ctrl.valid <= 1'b0;
    end else if (en) begin
      c_e      <= in_ctrl;
      c_p      <= c_e;
      out_ctrl <= '{valid: c_p.valid,
                    face:  c_p.face,
                    neg:   {n[2][tfn_pkg::CROSS_W-1], n[1][tfn_pkg::CROSS_W-1],
                            n[0][tfn_pkg::CROSS_W-1]},
                    zero:  (n[0] == '0) && (n[1] == '0) && (n[2] == '0)};
    end
  end

endmodule

// File: rtl/tfn_norm_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Normalization setup
// Squares of the magnitudes from split 17x17 products, their sum, and the
// start values of the root search. Four register stages.
// ----------------------------------------------------------------------------
module tfn_norm_setup (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  tfn_pkg::ctrl_t            in_ctrl,
  input  logic [tfn_pkg::MAG_W-1:0] mag [tfn_pkg::LANES],
  output tfn_pkg::ctrl_t            out_ctrl,
  output tfn_pkg::res_t             r [tfn_pkg::LANES],
  output tfn_pkg::res_t             a [tfn_pkg::LANES],
  output tfn_pkg::res_t             b [tfn_pkg::LANES]
);

  logic [tfn_pkg::HPROD_W-1:0] hh [tfn_pkg::LANES];
  logic [tfn_pkg::HPROD_W-1:0] hl [tfn_pkg::LANES];
  logic [tfn_pkg::HPROD_W-1:0] ll [tfn_pkg::LANES];
  logic [tfn_pkg::SQ_W-1:0]    sq [tfn_pkg::LANES];
  logic [tfn_pkg::SQ_W-1:0]    sq_d [tfn_pkg::LANES];
  logic [tfn_pkg::SUM_W-1:0]   s;
  tfn_pkg::ctrl_t              c1;
  tfn_pkg::ctrl_t              c2;
  tfn_pkg::ctrl_t              c3;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < tfn_pkg::LANES; i++) begin
        hh[i] <= mag[i][tfn_pkg::MAG_W-1:tfn_pkg::HALF_W] *
                 mag[i][tfn_pkg::MAG_W-1:tfn_pkg::HALF_W];
        hl[i] <= mag[i][tfn_pkg::MAG_W-1:tfn_pkg::HALF_W] * mag[i][tfn_pkg::HALF_W-1:0];
        ll[i] <= mag[i][tfn_pkg::HALF_W-1:0] * mag[i][tfn_pkg::HALF_W-1:0];
        sq[i] <= (tfn_pkg::SQ_W'(hh[i]) << (2 * tfn_pkg::HALF_W))
               + (tfn_pkg::SQ_W'(hl[i]) << (tfn_pkg::HALF_W + 1))
               + tfn_pkg::SQ_W'(ll[i]);
        sq_d[i] <= sq[i];
        r[i] <= (tfn_pkg::RES_W'(sq_d[i]) << tfn_pkg::T_SHIFT) - tfn_pkg::RES_W'(s);
        a[i] <= -(tfn_pkg::RES_W'(s) << tfn_pkg::A_SHIFT);
        b[i] <= tfn_pkg::RES_W'(s) << tfn_pkg::B_SHIFT;
      end
      s <= tfn_pkg::SUM_W'(sq[0]) + tfn_pkg::SUM_W'(sq[1]) + tfn_pkg::SUM_W'(sq[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1.valid       <= 1'b0;
      c2.valid       <= 1'b0;
      c3.valid       <= 1'b0;
      out_ctrl.valid <= 1'b0;
    end else if (en) begin
      c1       <= in_ctrl;
      c2       <= c1;
      c3       <= c2;
      out_ctrl <= c3;
    end
  end

endmodule

// File: rtl/tfn_root_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Root search step
// Decide one bit of round(16384 * m / sqrt(s)) by exact integer compare.
// r holds T - s*k^2, a holds s*k scaled, b holds s scaled for this bit.
// ----------------------------------------------------------------------------
module tfn_root_step (
  input  logic                    clk,
  input  logic                    en,
  input  tfn_pkg::res_t           r,
  input  tfn_pkg::res_t           a,
  input  tfn_pkg::res_t           b,
  input  logic [tfn_pkg::Q_W-1:0] q,
  output tfn_pkg::res_t           r_q,
  output tfn_pkg::res_t           a_q,
  output tfn_pkg::res_t           b_q,
  output logic [tfn_pkg::Q_W-1:0] q_q
);

  tfn_pkg::res_t diff;
  logic          take;

  assign diff = r - a - b;
  assign take = ~diff[tfn_pkg::RES_W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      r_q <= take ? diff : r;
      a_q <= (a >>> 1) + (take ? b : tfn_pkg::res_t'(0));
      b_q <= b >>> 2;
      q_q <= {q[tfn_pkg::Q_W-2:0], take};
    end
  end

endmodule

// File: rtl/triangle_face_normal_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle face normal unit
// Vertex store plus a fully pipelined unit normal engine for triangle faces.
// ----------------------------------------------------------------------------
// One transaction enters per clock while no result is stalled, loads and
// faces mixed freely. A load writes a signed Q8.8 vertex into the 1024-entry
// store and gives no result; a face reads three corners, forms b-a and c-b,
// crosses them and returns round(16384 * n / |n|) per component as signed
// Q1.14, or zeros with degenerate set when the cross product vanishes. A face
// may name a vertex loaded in the very previous transaction. A face passes 24
// register stages: one for the store read (taken at the accepting edge),
// three for edges and cross product, four for squares, sum and search setup,
// fifteen for the bit-per-stage root search (one stage per output bit), one
// for the output register. Results leave in order. A stalled result register
// freezes the whole pipeline, so req.ready follows rsp.ready while a result
// is waiting. Vertices must be written before a face reads them.
// ----------------------------------------------------------------------------
module triangle_face_normal_unit (
  input  logic       clk,
  input  logic       rst,
  tfn_in_if.sink     req,
  tfn_out_if.source  rsp
);

  logic                                        adv;
  logic                                        accept;
  logic [tfn_pkg::LANES-1:0][tfn_pkg::VIDX_W-1:0] rd_idx;
  tfn_pkg::vertex_t                            wr_data;
  tfn_pkg::vertex_t                            vtx [tfn_pkg::LANES];
  tfn_pkg::ctrl_t                              rd_ctrl;
  tfn_pkg::ctrl_t                              x_ctrl;
  logic [tfn_pkg::MAG_W-1:0]                   mag [tfn_pkg::LANES];
  tfn_pkg::ctrl_t                              rctrl [tfn_pkg::Q_STAGES+1];
  tfn_pkg::res_t                    rr [tfn_pkg::Q_STAGES+1][tfn_pkg::LANES];
  tfn_pkg::res_t                    ra [tfn_pkg::Q_STAGES+1][tfn_pkg::LANES];
  tfn_pkg::res_t                    rb [tfn_pkg::Q_STAGES+1][tfn_pkg::LANES];
  logic [tfn_pkg::Q_W-1:0]          rq [tfn_pkg::Q_STAGES+1][tfn_pkg::LANES];
  logic signed [tfn_pkg::NORM_W-1:0]           norm [tfn_pkg::LANES];
  logic                                        out_valid;

  // advance the whole pipeline unless a finished result is stuck
  assign adv       = ~out_valid | rsp.ready;
  assign req.ready = adv;
  assign accept    = req.valid & adv;

  assign wr_data = '{x: req.coord_x, y: req.coord_y, z: req.coord_z};
  assign rd_idx  = {req.corner_c, req.corner_b, req.corner_a};

  tfn_vertex_store u_store (
    .clk     (clk),
    .en      (adv),
    .wr_en   (accept && (req.operation == tfn_pkg::OP_LOAD)),
    .wr_idx  (req.vertex_index),
    .wr_data (wr_data),
    .rd_idx  (rd_idx),
    .rd_data (vtx)
  );

  // control word rides beside the store read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ctrl.valid <= 1'b0;
    end else if (adv) begin
      rd_ctrl.valid <= accept && (req.operation == tfn_pkg::OP_FACE);
      rd_ctrl.face  <= req.face_index;
      rd_ctrl.neg   <= '0;
      rd_ctrl.zero  <= 1'b0;
    end
  end

  tfn_cross u_cross (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_ctrl  (rd_ctrl),
    .va       (vtx[0]),
    .vb       (vtx[1]),
    .vc       (vtx[2]),
    .out_ctrl (x_ctrl),
    .mag      (mag)
  );

  tfn_norm_setup u_setup (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_ctrl  (x_ctrl),
    .mag      (mag),
    .out_ctrl (rctrl[0]),
    .r        (rr[0]),
    .a        (ra[0]),
    .b        (rb[0])
  );

  // root search: one output bit per stage, MSB first
  for (genvar st = 0; st < tfn_pkg::Q_STAGES; st++) begin : g_root
    for (genvar ln = 0; ln < tfn_pkg::LANES; ln++) begin : g_lane
      if (st == 0) begin : g_seed
        assign rq[0][ln] = '0;
      end
      tfn_root_step u_step (
        .clk (clk),
        .en  (adv),
        .r   (rr[st][ln]),
        .a   (ra[st][ln]),
        .b   (rb[st][ln]),
        .q   (rq[st][ln]),
        .r_q (rr[st+1][ln]),
        .a_q (ra[st+1][ln]),
        .b_q (rb[st+1][ln]),
        .q_q (rq[st+1][ln])
      );
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        rctrl[st+1].valid <= 1'b0;
      end else if (adv) begin
        rctrl[st+1] <= rctrl[st];
      end
    end
  end

  // apply sign; a zero cross product gives zeros
  always_comb begin
    for (int i = 0; i < tfn_pkg::LANES; i++) begin
      if (rctrl[tfn_pkg::Q_STAGES].zero) begin
        norm[i] = '0;
      end else if (rctrl[tfn_pkg::Q_STAGES].neg[i]) begin
        norm[i] = -tfn_pkg::NORM_W'(rq[tfn_pkg::Q_STAGES][i]);
      end else begin
        norm[i] = tfn_pkg::NORM_W'(rq[tfn_pkg::Q_STAGES][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= rctrl[tfn_pkg::Q_STAGES].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.face_number <= rctrl[tfn_pkg::Q_STAGES].face;
      rsp.normal_x    <= norm[0];
      rsp.normal_y    <= norm[1];
      rsp.normal_z    <= norm[2];
      rsp.degenerate  <= rctrl[tfn_pkg::Q_STAGES].zero;
    end
  end

  assign rsp.valid = out_valid;

  // a degenerate face carries an all-zero normal
  a_degen_zero : assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.degenerate |->
      rsp.normal_x == 0 && rsp.normal_y == 0 && rsp.normal_z == 0)
    else $error("degenerate face with nonzero normal");

  // a unit vector has a component of at least 1/sqrt(3)
  a_unit_len : assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.degenerate |->
      rsp.normal_x >= 9000 || rsp.normal_x <= -9000 ||
      rsp.normal_y >= 9000 || rsp.normal_y <= -9000 ||
      rsp.normal_z >= 9000 || rsp.normal_z <= -9000)
    else $error("normal too short");

  // components stay inside Q1.14 unit range
  a_range : assert property (@(posedge clk) disable iff (rst)
    rsp.valid |->
      rsp.normal_x <= 16384 && rsp.normal_x >= -16384 &&
      rsp.normal_y <= 16384 && rsp.normal_y >= -16384 &&
      rsp.normal_z <= 16384 && rsp.normal_z >= -16384)
    else $error("normal component out of range");

  // a stall freezes the pipeline
  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(rd_ctrl.valid) && $stable(rctrl[tfn_pkg::Q_STAGES].valid))
    else $error("pipeline moved during stall");

endmodule
